>>> hw/rtl/aac_pkg.sv
`timescale 1ns / 1ps

package aac_pkg;

  localparam int DEFAULT_SAMPLE_BITS = 16;

  localparam int AXIS_W     = 16;
  localparam int THR_W      = 12;
  localparam int CNT_W      = 8;
  localparam int CPG_W      = 16;
  localparam int DEV_W      = 13;
  localparam int LVL_W      = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MG_PER_G = 1000;
  localparam int DEV_MAX  = 2519;
  localparam int Q_MAX    = DEV_MAX + MG_PER_G;
  localparam int Q_W      = 12;
  // root * 1000 needs 10 more bits than the root
  localparam int SCALE_GROW = 10;

  localparam logic [THR_W-1:0] RST_THRESH = THR_W'(400);
  localparam logic [CNT_W-1:0] RST_WINDOW = CNT_W'(200);
  localparam logic [CNT_W-1:0] RST_NORMAL = CNT_W'(50);
  localparam logic [CNT_W-1:0] RST_HIGH   = CNT_W'(100);
  localparam logic [CPG_W-1:0] RST_CPG    = CPG_W'(16129);

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_ON     = 2'd1,
    MODE_OFF    = 2'd2
  } mode_t;

  typedef enum logic [LVL_W-1:0] {
    LVL_OFF     = 2'd0,
    LVL_NORMAL  = 2'd1,
    LVL_HIGH    = 2'd2,
    LVL_EXTREME = 2'd3
  } level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH = 3'd0,
    CFG_WINDOW = 3'd1,
    CFG_NORMAL = 3'd2,
    CFG_HIGH   = 3'd3,
    CFG_CPG    = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUMSQ,
    ST_ROOT,
    ST_SCALE,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // status of one serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } aac_stat_t;

endpackage

>>> hw/rtl/aac_sumsq.sv
`timescale 1ns / 1ps

module aac_sumsq
  import aac_pkg::*;
#(
  parameter int SB = DEFAULT_SAMPLE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SB-1:0]   mag_a,
  input  logic [SB-1:0]   mag_b,
  input  logic [SB-1:0]   mag_c,
  output aac_stat_t       stat,
  output logic [2*SB-1:0] sum
);

  localparam int SW = 2 * SB;
  localparam int BW = $clog2(SB);
  localparam logic [1:0] LAST_AXIS = 2'd2;

  logic [SW-1:0] mcand_r, mcand_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [SB-1:0] mplier_r, mplier_nxt;
  logic [SB-1:0] next_b_r, next_b_nxt;
  logic [SB-1:0] next_c_r, next_c_nxt;
  logic [BW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [1:0]    axis_r, axis_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          last_bit;

  assign last_bit = (bit_cnt_r == BW'(SB - 1));

  // shift-add squarer: one multiplier bit per cycle, axes one after another
  always_comb begin
    mcand_nxt   = mcand_r;
    acc_nxt     = acc_r;
    mplier_nxt  = mplier_r;
    next_b_nxt  = next_b_r;
    next_c_nxt  = next_c_r;
    bit_cnt_nxt = bit_cnt_r;
    axis_nxt    = axis_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    if (start) begin
      acc_nxt     = '0;
      mcand_nxt   = SW'(mag_a);
      mplier_nxt  = mag_a;
      next_b_nxt  = mag_b;
      next_c_nxt  = mag_c;
      bit_cnt_nxt = '0;
      axis_nxt    = '0;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt   = mcand_r << 1;
      mplier_nxt  = mplier_r >> 1;
      bit_cnt_nxt = bit_cnt_r + 1'b1;
      if (last_bit) begin
        bit_cnt_nxt = '0;
        mcand_nxt   = SW'(next_b_r);
        mplier_nxt  = next_b_r;
        next_b_nxt  = next_c_r;
        axis_nxt    = axis_r + 1'b1;
        if (axis_r == LAST_AXIS) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r   <= mcand_nxt;
    acc_r     <= acc_nxt;
    mplier_r  <= mplier_nxt;
    next_b_r  <= next_b_nxt;
    next_c_r  <= next_c_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    axis_r    <= axis_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign sum       = acc_r;

endmodule

>>> hw/rtl/aac_isqrt.sv
`timescale 1ns / 1ps

module aac_isqrt
  import aac_pkg::*;
#(
  parameter int SB = DEFAULT_SAMPLE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*SB-1:0] radicand,
  output aac_stat_t       stat,
  output logic [SB-1:0]   root
);

  localparam int SW = 2 * SB;

  logic [SW-1:0] n_r, n_nxt;
  logic [SW-1:0] res_r, res_nxt;
  logic [SW-1:0] bit_r, bit_nxt;
  logic [SW-1:0] trial;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  assign trial = res_r + bit_r;

  // digit-by-digit root, one result bit per cycle; bit_r walks down by 2
  always_comb begin
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = radicand;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(SW-2){1'b0}}};
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt   = n_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = res_r[SB-1:0];

endmodule

>>> hw/rtl/aac_div.sv
`timescale 1ns / 1ps

module aac_div
  import aac_pkg::*;
#(
  parameter int DW = DEFAULT_SAMPLE_BITS + SCALE_GROW,
  parameter int VW = CPG_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output aac_stat_t     stat,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  // restoring division, one quotient bit per cycle shifted into quo_r
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VW-1:0] : trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

>>> hw/rtl/accel_activity_classifier.sv
`timescale 1ns / 1ps

// Activity classifier for three-axis accelerometer items. An item is a sample
// (mode 0) or an on (1) / off (2) command. While on, each sample's magnitude
// sqrt(x^2+y^2+z^2) is turned into a deviation from 1 g in mg, saturated at
// 2519; running peak and least deviation are kept forever, and samples above
// the motion threshold are counted. When the window fills, the window's last
// sample reports level 1/2/3 with its detection count; switching off reports
// level 0. A sample holds the block from its accept to the next accept while
// it passes the bit-serial squarer, root and divider and the sequencing
// states, and a sample that reports also passes the emit state. An off
// command that reports passes the emit state too. Input is taken only
// between items; a pending result waits in the output register without
// holding off the next item, but a second report holds the input until the
// first one is taken. Config writes are always ready and belong between
// items, while nothing is in flight.

module accel_activity_classifier
  import aac_pkg::*;
#(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [MODE_W-1:0]            in_mode,
  input  logic signed [AXIS_W-1:0]     in_accel_x,
  input  logic signed [AXIS_W-1:0]     in_accel_y,
  input  logic signed [AXIS_W-1:0]     in_accel_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LVL_W-1:0]             out_activity_level,
  output logic [CNT_W-1:0]             out_detections,
  output logic signed [DEV_W-1:0]      out_peak_deviation,
  output logic signed [DEV_W-1:0]      out_least_deviation,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int SW = 2 * SB;
  localparam int PW = SB + SCALE_GROW;

  // config registers
  logic [THR_W-1:0] thresh_r, thresh_nxt;
  logic [CNT_W-1:0] window_r, window_nxt;
  logic [CNT_W-1:0] normal_r, normal_nxt;
  logic [CNT_W-1:0] high_r, high_nxt;
  logic [CPG_W-1:0] cpg_r, cpg_nxt;

  state_t                  state_r, state_nxt;
  logic                    powered_r, powered_nxt;
  logic [CNT_W-1:0]        smp_cnt_r, smp_cnt_nxt;
  logic [CNT_W-1:0]        det_cnt_r, det_cnt_nxt;
  logic signed [DEV_W-1:0] max_dev_r, max_dev_nxt;
  logic signed [DEV_W-1:0] min_dev_r, min_dev_nxt;
  logic [PW-1:0]           prod_r, prod_nxt;
  logic signed [DEV_W-1:0] dev_r, dev_nxt;
  level_t                  pend_lvl_r, pend_lvl_nxt;
  logic [CNT_W-1:0]        pend_det_r, pend_det_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]        out_lvl_r, out_lvl_nxt;
  logic [CNT_W-1:0]        out_det_r, out_det_nxt;
  logic signed [DEV_W-1:0] out_peak_r, out_peak_nxt;
  logic signed [DEV_W-1:0] out_least_r, out_least_nxt;

  logic [SB-1:0] raw_x, raw_y, raw_z;
  logic [SB-1:0] mag_x, mag_y, mag_z;
  logic          in_acc;
  logic          sq_start, rt_start, dv_start;
  aac_stat_t     sq_stat, rt_stat, dv_stat;
  logic [SW-1:0] sq_sum;
  logic [SB-1:0] root;
  logic [PW-1:0] quo;
  logic [CPG_W-1:0] divisor;
  logic [Q_W-1:0]   q_sat;
  logic          hit;
  logic [CNT_W-1:0] det_inc, smp_inc;

  assign raw_x = in_accel_x[SB-1:0];
  assign raw_y = in_accel_y[SB-1:0];
  assign raw_z = in_accel_z[SB-1:0];
  // two's complement magnitude; the most negative value maps to 2^(SB-1)
  assign mag_x = raw_x[SB-1] ? (~raw_x + 1'b1) : raw_x;
  assign mag_y = raw_y[SB-1] ? (~raw_y + 1'b1) : raw_y;
  assign mag_z = raw_z[SB-1] ? (~raw_z + 1'b1) : raw_z;

  assign in_acc  = in_valid && in_ready;
  assign divisor = (cpg_r == '0) ? CPG_W'(1) : cpg_r;
  assign q_sat   = (quo > PW'(Q_MAX)) ? Q_W'(Q_MAX) : quo[Q_W-1:0];

  assign hit     = dev_r > $signed({1'b0, thresh_r});
  assign det_inc = (hit && det_cnt_r != '1) ? det_cnt_r + 1'b1 : det_cnt_r;
  assign smp_inc = (smp_cnt_r != '1) ? smp_cnt_r + 1'b1 : smp_cnt_r;

  aac_sumsq #(
    .SB (SB)
  ) u_sumsq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .mag_a (mag_x),
    .mag_b (mag_y),
    .mag_c (mag_z),
    .stat  (sq_stat),
    .sum   (sq_sum)
  );

  aac_isqrt #(
    .SB (SB)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (sq_sum),
    .stat     (rt_stat),
    .root     (root)
  );

  aac_div #(
    .DW (PW),
    .VW (CPG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (prod_r),
    .divisor  (divisor),
    .stat     (dv_stat),
    .quotient (quo)
  );

  assign rt_start = sq_stat.done;

  // config port
  always_comb begin
    thresh_nxt = thresh_r;
    window_nxt = window_r;
    normal_nxt = normal_r;
    high_nxt   = high_r;
    cpg_nxt    = cpg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESH: thresh_nxt = cfg_data[THR_W-1:0];
        CFG_WINDOW: window_nxt = cfg_data[CNT_W-1:0];
        CFG_NORMAL: normal_nxt = cfg_data[CNT_W-1:0];
        CFG_HIGH:   high_nxt   = cfg_data[CNT_W-1:0];
        CFG_CPG:    cpg_nxt    = cfg_data[CPG_W-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer and stats
  always_comb begin
    state_nxt     = state_r;
    powered_nxt   = powered_r;
    smp_cnt_nxt   = smp_cnt_r;
    det_cnt_nxt   = det_cnt_r;
    max_dev_nxt   = max_dev_r;
    min_dev_nxt   = min_dev_r;
    prod_nxt      = prod_r;
    dev_nxt       = dev_r;
    pend_lvl_nxt  = pend_lvl_r;
    pend_det_nxt  = pend_det_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_lvl_nxt   = out_lvl_r;
    out_det_nxt   = out_det_r;
    out_peak_nxt  = out_peak_r;
    out_least_nxt = out_least_r;
    in_ready      = 1'b0;
    sq_start      = 1'b0;
    dv_start      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_mode)
            MODE_SAMPLE: begin
              if (powered_r) begin
                sq_start  = 1'b1;
                state_nxt = ST_SUMSQ;
              end
            end
            MODE_ON: powered_nxt = 1'b1;
            MODE_OFF: begin
              if (powered_r) begin
                powered_nxt  = 1'b0;
                pend_lvl_nxt = LVL_OFF;
                pend_det_nxt = '0;
                state_nxt    = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SUMSQ: begin
        if (sq_stat.done) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rt_stat.done) begin
          // root * 1000 = (root << 10) - (root << 5) + (root << 3)
          prod_nxt  = (PW'(root) << 10) - (PW'(root) << 5) + (PW'(root) << 3);
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        dv_start  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (dv_stat.done) begin
          dev_nxt   = $signed({1'b0, q_sat}) - DEV_W'(MG_PER_G);
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (dev_r > max_dev_r) begin
          max_dev_nxt = dev_r;
        end
        if (dev_r < min_dev_r) begin
          min_dev_nxt = dev_r;
        end
        if (smp_inc >= window_r) begin
          if (det_inc <= normal_r) begin
            pend_lvl_nxt = LVL_NORMAL;
          end else if (det_inc <= high_r) begin
            pend_lvl_nxt = LVL_HIGH;
          end else begin
            pend_lvl_nxt = LVL_EXTREME;
          end
          pend_det_nxt = det_inc;
          smp_cnt_nxt  = '0;
          det_cnt_nxt  = '0;
          state_nxt    = ST_EMIT;
        end else begin
          smp_cnt_nxt = smp_inc;
          det_cnt_nxt = det_inc;
          state_nxt   = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_lvl_nxt   = pend_lvl_r;
          out_det_nxt   = pend_det_r;
          out_peak_nxt  = max_dev_r;
          out_least_nxt = min_dev_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      powered_r   <= 1'b0;
      smp_cnt_r   <= '0;
      det_cnt_r   <= '0;
      max_dev_r   <= '0;
      min_dev_r   <= DEV_W'(DEV_MAX);
      out_valid_r <= 1'b0;
      thresh_r    <= RST_THRESH;
      window_r    <= RST_WINDOW;
      normal_r    <= RST_NORMAL;
      high_r      <= RST_HIGH;
      cpg_r       <= RST_CPG;
    end else begin
      state_r     <= state_nxt;
      powered_r   <= powered_nxt;
      smp_cnt_r   <= smp_cnt_nxt;
      det_cnt_r   <= det_cnt_nxt;
      max_dev_r   <= max_dev_nxt;
      min_dev_r   <= min_dev_nxt;
      out_valid_r <= out_valid_nxt;
      thresh_r    <= thresh_nxt;
      window_r    <= window_nxt;
      normal_r    <= normal_nxt;
      high_r      <= high_nxt;
      cpg_r       <= cpg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    dev_r       <= dev_nxt;
    pend_lvl_r  <= pend_lvl_nxt;
    pend_det_r  <= pend_det_nxt;
    out_lvl_r   <= out_lvl_nxt;
    out_det_r   <= out_det_nxt;
    out_peak_r  <= out_peak_nxt;
    out_least_r <= out_least_nxt;
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_activity_level  = out_lvl_r;
  assign out_detections      = out_det_r;
  assign out_peak_deviation  = out_peak_r;
  assign out_least_deviation = out_least_r;

  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({sq_stat.busy, rt_stat.busy, dv_stat.busy}))
    else $error("more than one arithmetic unit busy");

  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(sq_stat.busy || rt_stat.busy || dv_stat.busy))
    else $error("input ready while a sample is in flight");

  a_off_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_OFF) && powered_r) |=> (state_r == ST_EMIT) && !powered_r)
    else $error("switch-off did not schedule a report");

  a_off_no_det: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_activity_level == LVL_OFF)) |-> (out_detections == '0))
    else $error("level-off report carries detections");

endmodule
